[rtl/qdf_pkg.sv]
// qdf_pkg: shared widths, codes and control structs for the quorum duplicate filter
`timescale 1ns / 1ps
package qdf_pkg;

    localparam int KEY_W       = 64;
    localparam int TYPE_W      = 16;
    localparam int FLAG_W      = 8;
    localparam int VERDICT_W   = 2;
    localparam int CFG_W       = 4;
    localparam int CFG_INDEX_W = 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_REPLICA_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_QUORUM  = 1'd1;

    localparam logic [CFG_W-1:0] REPLICA_COUNT_RESET = 4'd3;
    localparam logic [CFG_W-1:0] WRITE_QUORUM_RESET  = 4'd2;

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_FORWARD = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_DROP    = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_RETURN  = 2'd2;

    // message types that go back to the control function at quorum
    localparam logic [TYPE_W-1:0] TYPE_RETURN_A = 16'd91;
    localparam logic [TYPE_W-1:0] TYPE_RETURN_B = 16'd234;

    localparam logic [FLAG_W-1:0] FLAG_RETURNED    = 8'd1;
    localparam logic [FLAG_W-1:0] FLAG_CLEARED     = 8'd0;
    localparam logic [FLAG_W-1:0] FLAG_RETURN_MARK = 8'd77;

    // controller to datapath
    typedef struct packed {
        logic clear;   // write one zero row of the clearing pass
        logic start;   // latch request, start set index
        logic rd_en;   // read the set row
        logic load;    // update the row, load the result register
    } qdf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic idx_done;
    } qdf_status_t;

endpackage

[rtl/qdf_if.sv]
// qdf_if: request and result channel interfaces
`timescale 1ns / 1ps
interface qdf_resp_if
    import qdf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  clock_key;
    logic [TYPE_W-1:0] message_type;
    logic [FLAG_W-1:0] flag_byte;

    modport source (output valid, clock_key, message_type, flag_byte, input ready);
    modport sink   (input valid, clock_key, message_type, flag_byte, output ready);
endinterface

interface qdf_result_if
    import qdf_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [FLAG_W-1:0]    flag_byte_out;
    logic                 not_stored;

    modport source (output valid, verdict, flag_byte_out, not_stored, input ready);
    modport sink   (input valid, verdict, flag_byte_out, not_stored, output ready);
endinterface

[rtl/quorum_duplicate_filter_top.sv]
// quorum_duplicate_filter_top: quorum filter for replicated responses
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+------------------------------------------
//  resp     | in  | valid / ready   | clock_key[64] message_type[16] flag_byte[8]
//  result   | out | valid / ready   | verdict[2] flag_byte_out[8] not_stored[1]
//  cfg      | in  | cfg_we only     | cfg_index[1] cfg_data[4]
//
//  one request at a time: accept, set index, row read, row update; when SETS is
//  a power of two the set index is taken from the low key bits, otherwise the
//  key modulo unit works through the four 16-bit key digits one after another
//  after reset a clearing pass writes a zero row to every set, resp.ready is low
//  a finished result waits in the result register; the next request is taken
//  only once that register is empty or in the cycle its result is taken
`timescale 1ns / 1ps
module quorum_duplicate_filter_top
    import qdf_pkg::*;
#(
    parameter int SETS       = 256,
    parameter int WAYS       = 4,
    parameter int COUNT_BITS = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    qdf_resp_if.sink               resp,
    qdf_result_if.source           result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    // command and status between controller and datapath
    qdf_cmd_t    cmd;
    qdf_status_t status;

    // controller: sequencing, handshakes, result valid
    qdf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .resp_valid   (resp.valid),
        .resp_ready   (resp.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .status       (status)
    );

    // datapath: set table with count update, config registers, result payload
    qdf_dp #(
        .SETS       (SETS),
        .WAYS       (WAYS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_key        (resp.clock_key),
        .in_type       (resp.message_type),
        .in_flag       (resp.flag_byte),
        .verdict       (result.verdict),
        .flag_byte_out (result.flag_byte_out),
        .not_stored    (result.not_stored)
    );

endmodule

[rtl/qdf_ctrl.sv]
// qdf_ctrl: controller state machine of the quorum duplicate filter
`timescale 1ns / 1ps
module qdf_ctrl
    import qdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        resp_valid,
    output logic        resp_ready,
    output logic        result_valid,
    input  logic        result_ready,
    output qdf_cmd_t    cmd,
    input  qdf_status_t status
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_LOOKUP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // take a request only when the result register will be free by lookup time
    assign resp_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || result_ready);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (resp_valid && resp_ready)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX:
            begin
                if (status.idx_done)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.load       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/qdf_dp.sv]
// qdf_dp: datapath with set table, set index unit, config and result registers
`timescale 1ns / 1ps
module qdf_dp
    import qdf_pkg::*;
#(
    parameter int SETS       = 256,
    parameter int WAYS       = 4,
    parameter int COUNT_BITS = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  qdf_cmd_t               cmd,
    output qdf_status_t            status,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic [KEY_W-1:0]       in_key,
    input  logic [TYPE_W-1:0]      in_type,
    input  logic [FLAG_W-1:0]      in_flag,
    output logic [VERDICT_W-1:0]   verdict,
    output logic [FLAG_W-1:0]      flag_byte_out,
    output logic                   not_stored
);

    localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_W    = 1 + KEY_W + COUNT_BITS;
    localparam int ROW_W    = WAYS * WAY_W;
    localparam int CMP_W    = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam int VALID_POS = WAY_W - 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // configuration registers
    logic [CFG_W-1:0] replica_reg, quorum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replica_reg <= REPLICA_COUNT_RESET;
            quorum_reg  <= WRITE_QUORUM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REPLICA_COUNT: replica_reg <= cfg_data;
                REG_WRITE_QUORUM:  quorum_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // latched request
    logic [KEY_W-1:0]  key_reg;
    logic [TYPE_W-1:0] type_reg;
    logic [FLAG_W-1:0] flag_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg  <= in_key;
            type_reg <= in_type;
            flag_reg <= in_flag;
        end
    end

    // set index: key modulo SETS
    logic [SET_BITS-1:0] set_idx;

    generate
        if (SETS == 1)
        begin : g_one_set
            assign set_idx         = '0;
            assign status.idx_done = 1'b1;
        end
        else if ((SETS & (SETS - 1)) == 0)
        begin : g_pow2
            assign set_idx         = key_reg[SET_BITS-1:0];
            assign status.idx_done = 1'b1;
        end
        else
        begin : g_recip_mod
            // each 16-bit key digit in turn, most significant first:
            // quotient estimate by reciprocal multiply, then remainder and one
            // correcting subtract (the estimate is low by at most one)
            localparam int DIGIT_W = 16;
            localparam int DIGITS  = KEY_W / DIGIT_W;
            localparam int STEPS   = 2 * DIGITS;
            localparam int STEP_W  = $clog2(STEPS + 1);
            localparam int X_W     = SET_BITS + DIGIT_W;
            localparam int RCP_W   = 32;
            localparam int PROD_W  = X_W + RCP_W;
            localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << RCP_W) / 64'(SETS));
            localparam logic [X_W-1:0]   MOD_X = X_W'(SETS);

            logic [KEY_W-1:0]    shift_reg;
            logic [SET_BITS-1:0] rem_reg;
            logic [X_W-1:0]      x_reg;
            logic [DIGIT_W-1:0]  q_reg;
            logic [STEP_W-1:0]   step_reg;
            logic [X_W-1:0]      x_next;
            logic [PROD_W-1:0]   prod;
            logic [X_W-1:0]      r_full;
            logic [SET_BITS:0]   r_est;
            logic [SET_BITS-1:0] rem_fix;

            assign x_next  = {rem_reg, shift_reg[KEY_W-1 -: DIGIT_W]};
            assign prod    = PROD_W'(x_next) * PROD_W'(RECIP);
            assign r_full  = x_reg - X_W'(q_reg) * MOD_X;
            assign r_est   = r_full[SET_BITS:0];
            assign rem_fix = (r_est >= (SET_BITS + 1)'(SETS))
                           ? SET_BITS'(r_est - (SET_BITS + 1)'(SETS))
                           : SET_BITS'(r_est);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    step_reg <= STEP_W'(STEPS);
                end
                else if (cmd.start)
                begin
                    step_reg <= '0;
                end
                else if (step_reg != STEP_W'(STEPS))
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (cmd.start)
                begin
                    shift_reg <= in_key;
                    rem_reg   <= '0;
                end
                else if (step_reg != STEP_W'(STEPS))
                begin
                    if (!step_reg[0])
                    begin
                        x_reg <= x_next;
                        q_reg <= prod[RCP_W +: DIGIT_W];
                    end
                    else
                    begin
                        shift_reg <= {shift_reg[KEY_W-DIGIT_W-1:0], DIGIT_W'(0)};
                        rem_reg   <= rem_fix;
                    end
                end
            end

            assign set_idx         = rem_reg;
            assign status.idx_done = (step_reg == STEP_W'(STEPS));
        end
    endgenerate

    // clearing pass address
    logic [SET_BITS-1:0] clear_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
        end
    end

    assign status.clear_last = (clear_addr_reg == SET_BITS'(SETS - 1));

    // set table, one row per set: per way {valid, key, count}
    logic [ROW_W-1:0]    mem [SETS];
    logic [ROW_W-1:0]    rd_row_reg;
    logic [ROW_W-1:0]    wr_row;
    logic                mem_we;
    logic [SET_BITS-1:0] mem_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= cmd.clear ? '0 : wr_row;
        end
        if (cmd.rd_en)
        begin
            rd_row_reg <= mem[set_idx];
        end
    end

    // way search
    logic                hit_found, free_found;
    logic [WAY_BITS-1:0] hit_way, free_way, sel_way;
    logic [WAY_W-1:0]    way_v;

    always_comb
    begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        way_v      = '0;
        // downward so the lowest way wins
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            way_v = rd_row_reg[w*WAY_W +: WAY_W];
            if (way_v[VALID_POS])
            begin
                if (way_v[COUNT_BITS +: KEY_W] == key_reg)
                begin
                    hit_found = 1'b1;
                    hit_way   = WAY_BITS'(w);
                end
            end
            else
            begin
                free_found = 1'b1;
                free_way   = WAY_BITS'(w);
            end
        end
    end

    // count update and verdict
    logic [COUNT_BITS-1:0] old_cnt, new_cnt;
    logic                  returned, at_quorum, at_replica, store_new, keep_new;
    logic                  ret_type;
    logic [WAY_W-1:0]      new_way;
    logic [VERDICT_W-1:0]  verdict_next;
    logic [FLAG_W-1:0]     flag_next;
    logic                  not_stored_next;

    assign returned   = (flag_reg == FLAG_RETURNED);
    assign old_cnt    = rd_row_reg[int'(hit_way)*WAY_W +: COUNT_BITS];
    assign new_cnt    = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
    assign at_quorum  = (CMP_W'(new_cnt) == CMP_W'(quorum_reg));
    assign at_replica = (CMP_W'(new_cnt) == CMP_W'(replica_reg));
    assign ret_type   = (type_reg == TYPE_RETURN_A) || (type_reg == TYPE_RETURN_B);
    assign keep_new   = (replica_reg != CFG_W'(1));
    assign store_new  = !hit_found && keep_new && free_found;
    assign sel_way    = hit_found ? hit_way : free_way;
    assign new_way    = hit_found ? {!at_replica, key_reg, new_cnt}
                                  : {1'b1, key_reg, COUNT_ONE};

    always_comb
    begin
        wr_row = rd_row_reg;
        wr_row[int'(sel_way)*WAY_W +: WAY_W] = new_way;
    end

    assign mem_we   = cmd.clear || (cmd.load && !returned && (hit_found || store_new));
    assign mem_addr = cmd.clear ? clear_addr_reg : set_idx;

    always_comb
    begin
        flag_next       = flag_reg;
        not_stored_next = 1'b0;
        if (returned)
        begin
            verdict_next = VERDICT_FORWARD;
            flag_next    = FLAG_CLEARED;
        end
        else if (hit_found)
        begin
            if (at_quorum && ret_type)
            begin
                verdict_next = VERDICT_RETURN;
                flag_next    = FLAG_RETURN_MARK;
            end
            else if (at_quorum)
            begin
                verdict_next = VERDICT_FORWARD;
            end
            else
            begin
                verdict_next = VERDICT_DROP;
            end
        end
        else
        begin
            verdict_next    = (quorum_reg == CFG_W'(1)) ? VERDICT_FORWARD : VERDICT_DROP;
            not_stored_next = keep_new && !free_found;
        end
    end

    // result register
    logic [VERDICT_W-1:0] verdict_reg;
    logic [FLAG_W-1:0]    flag_out_reg;
    logic                 not_stored_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            verdict_reg    <= verdict_next;
            flag_out_reg   <= flag_next;
            not_stored_reg <= not_stored_next;
        end
    end

    assign verdict       = verdict_reg;
    assign flag_byte_out = flag_out_reg;
    assign not_stored    = not_stored_reg;

endmodule

[rtl/qdf_checker.sv]
// qdf_checker: port-level assertions for the quorum duplicate filter and its bind
`timescale 1ns / 1ps
module qdf_checker
    import qdf_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 resp_valid,
    input logic                 resp_ready,
    input logic                 result_valid,
    input logic                 result_ready,
    input logic [VERDICT_W-1:0] verdict,
    input logic [FLAG_W-1:0]    flag_byte_out
);

    // no request is taken while reset holds
    a_no_ready_in_reset: assert property (@(posedge clk) !rst_n |-> !resp_ready)
        else $error("resp ready during reset");

    // a stalled result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(verdict)
            && $stable(flag_byte_out))
        else $error("stalled result changed");

    // a new request is never taken while a result would still be stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        resp_ready && result_valid |-> result_ready)
        else $error("request taken over a stalled result");

    // only defined verdicts, and a return always carries the return mark
    a_return_mark: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (verdict == VERDICT_FORWARD) || (verdict == VERDICT_DROP)
            || ((verdict == VERDICT_RETURN) && (flag_byte_out == FLAG_RETURN_MARK)))
        else $error("bad verdict or missing return mark");

endmodule

bind quorum_duplicate_filter_top qdf_checker u_qdf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .resp_valid    (resp.valid),
    .resp_ready    (resp.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .verdict       (result.verdict),
    .flag_byte_out (result.flag_byte_out)
);

[tb/quorum_verdict_checker.sv]
// quorum_verdict_checker: predicts the verdict of every request and compares results
`timescale 1ns / 1ps
module quorum_verdict_checker
    import qdf_pkg::*;
#(
    parameter int SETS       = 256,
    parameter int WAYS       = 4,
    parameter int COUNT_BITS = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    qdf_resp_if                    resp,
    qdf_result_if                  result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    output int                     mismatches,
    output int                     outstanding
);

    localparam int ENTRIES = SETS * WAYS;
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [FLAG_W-1:0]    flag_byte_out;
        logic                 not_stored;
    } outcome_t;

    logic                  table_valid [ENTRIES];
    logic [KEY_W-1:0]      table_key   [ENTRIES];
    logic [COUNT_BITS-1:0] table_count [ENTRIES];
    logic [CFG_W-1:0]      replicas;
    logic [CFG_W-1:0]      quorum;
    outcome_t              outcome_q [$];

    function automatic outcome_t filter_response(input logic [KEY_W-1:0]  key,
                                                 input logic [TYPE_W-1:0] mtype,
                                                 input logic [FLAG_W-1:0] flag);
        outcome_t              o;
        int                    base;
        int                    hit;
        int                    spare;
        logic [COUNT_BITS-1:0] c;
        o.verdict       = VERDICT_DROP;
        o.flag_byte_out = flag;
        o.not_stored    = 1'b0;
        // returned copy passes straight through
        if (flag == FLAG_RETURNED)
        begin
            o.verdict       = VERDICT_FORWARD;
            o.flag_byte_out = FLAG_CLEARED;
            return o;
        end
        base  = int'(key % 64'(SETS)) * WAYS;
        hit   = -1;
        spare = -1;
        for (int w = 0; w < WAYS; w++)
        begin
            if (table_valid[base + w])
            begin
                if (hit < 0 && table_key[base + w] == key)
                    hit = base + w;
            end
            else if (spare < 0)
                spare = base + w;
        end
        if (hit >= 0)
        begin
            c = table_count[hit];
            if (c != COUNT_TOP)
                c = c + 1'b1;
            table_count[hit] = c;
            if (int'(c) == int'(replicas))
                table_valid[hit] = 1'b0;
            if (int'(c) == int'(quorum))
            begin
                if (mtype == TYPE_RETURN_A || mtype == TYPE_RETURN_B)
                begin
                    o.verdict       = VERDICT_RETURN;
                    o.flag_byte_out = FLAG_RETURN_MARK;
                end
                else
                    o.verdict = VERDICT_FORWARD;
            end
        end
        else
        begin
            // new key, count of one
            if (replicas != 1)
            begin
                if (spare >= 0)
                begin
                    table_valid[spare] = 1'b1;
                    table_key[spare]   = key;
                    table_count[spare] = COUNT_BITS'(1);
                end
                else
                    o.not_stored = 1'b1;
            end
            o.verdict = (quorum == 1) ? VERDICT_FORWARD : VERDICT_DROP;
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        outcome_t seen;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                table_valid[i] = 1'b0;
                table_key[i]   = '0;
                table_count[i] = '0;
            end
            replicas = REPLICA_COUNT_RESET;
            quorum   = WRITE_QUORUM_RESET;
            outcome_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_REPLICA_COUNT: replicas = cfg_data;
                    REG_WRITE_QUORUM:  quorum   = cfg_data;
                    default: ;
                endcase
            end
            // results first, so a request taken at this edge cannot pair with them
            if (result.valid && result.ready)
            begin
                seen = '{result.verdict, result.flag_byte_out, result.not_stored};
                if (outcome_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no request waiting:", $realtime,
                                 " verdict %0d flag %0d not_stored %0d",
                                 seen.verdict, seen.flag_byte_out, seen.not_stored);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (want !== seen)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: expected verdict %0d flag %0d",
                                     $realtime, want.verdict, want.flag_byte_out,
                                     " not_stored %0d, got verdict %0d flag %0d",
                                     want.not_stored, seen.verdict, seen.flag_byte_out,
                                     " not_stored %0d", seen.not_stored);
                    end
                end
            end
            if (resp.valid && resp.ready)
                outcome_q.insert(outcome_q.size(),
                                 filter_response(resp.clock_key, resp.message_type,
                                                 resp.flag_byte));
            outstanding = outcome_q.size();
        end
    end

endmodule

[tb/tb_quorum_duplicate_filter_top.sv]
// tb_quorum_duplicate_filter_top: stimulus, flow control and verdict for the quorum filter
`timescale 1ns / 1ps
module tb_quorum_duplicate_filter_top;
    import qdf_pkg::*;

    localparam int SETS             = 256;
    localparam int WAYS             = 4;
    localparam int COUNT_BITS       = 4;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 80;    // covers the slow modulo path too
    localparam int PHASES           = 10;
    localparam int RANDOM_PER_PHASE = 155;
    localparam int POOL_KEYS        = 14;    // spread over three sets so some set overflows

    // register settings per phase; phase 0 runs on the reset values
    localparam logic [CFG_W-1:0] PHASE_REPLICAS [PHASES] =
        '{4'd3, 4'd1, 4'd15, 4'd0, 4'd0, 4'd2, 4'd15, 4'd4, 4'd1, 4'd5};
    localparam logic [CFG_W-1:0] PHASE_QUORUM [PHASES] =
        '{4'd2, 4'd1, 4'd15, 4'd15, 4'd0, 4'd1, 4'd1, 4'd3, 4'd15, 4'd5};

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    int                     mismatches;
    int                     outstanding;
    int                     cycles = 0;
    int                     stall_left = 0;
    bit                     calm = 1'b0;   // set for the final phase: no idling at all

    qdf_resp_if   resp_ch ();
    qdf_result_if result_ch ();

    quorum_duplicate_filter_top #(
        .SETS       (SETS),
        .WAYS       (WAYS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .resp      (resp_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    quorum_verdict_checker #(
        .SETS       (SETS),
        .WAYS       (WAYS),
        .COUNT_BITS (COUNT_BITS)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .resp        (resp_ch),
        .result      (result_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit, far above the slowest legal run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** quorum_duplicate_filter_top: FAILED **");
            $finish;
        end
    end

    // result side back pressure: ready drops at random, in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end
        else if (!calm && rst_n && $urandom_range(0, 5) == 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= $urandom_range(0, 2);
        end
        else
            result_ch.ready <= 1'b1;
    end

    // offer one request and hold it until taken; sometimes a short gap comes first
    task automatic send_response(input logic [KEY_W-1:0]  key,
                                 input logic [TYPE_W-1:0] mtype,
                                 input logic [FLAG_W-1:0] flag);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            resp_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        resp_ch.valid        <= 1'b1;
        resp_ch.clock_key    <= key;
        resp_ch.message_type <= mtype;
        resp_ch.flag_byte    <= flag;
        @(posedge clk);
        while (!resp_ch.ready)
            @(posedge clk);
    endtask

    // stop offering, let every expected result come back, then let the block settle
    task automatic drain();
        resp_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [CFG_W-1:0] replicas,
                                  input logic [CFG_W-1:0] quorum);
        cfg_we    <= 1'b1;
        cfg_index <= REG_REPLICA_COUNT;
        cfg_data  <= replicas;
        @(posedge clk);
        cfg_index <= REG_WRITE_QUORUM;
        cfg_data  <= quorum;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        logic [KEY_W-1:0]  key;
        logic [TYPE_W-1:0] mtype;
        logic [FLAG_W-1:0] flag;
        logic [KEY_W-1:0]  pool [POOL_KEYS];
        int                pool_sets [3];
        int                pick;

        // every request input known from time zero
        rst_n                <= 1'b0;
        resp_ch.valid        <= 1'b0;
        resp_ch.clock_key    <= '0;
        resp_ch.message_type <= '0;
        resp_ch.flag_byte    <= '0;
        cfg_we               <= 1'b0;
        cfg_index            <= REG_REPLICA_COUNT;
        cfg_data             <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on reset values: replica count 3, quorum 2
        send_response('1, '1, FLAG_RETURNED);                     // returned copy
        send_response('0, '0, FLAG_CLEARED);                      // new key, drop
        send_response('0, TYPE_RETURN_A, 8'hFF);                  // quorum on 91: return
        send_response('0, TYPE_RETURN_B, 8'h80);                  // replica count: freed
        send_response('0, TYPE_RETURN_B, FLAG_CLEARED);           // same key is new again
        send_response('0, TYPE_RETURN_B, FLAG_RETURNED);          // returned copy, table kept
        send_response('0, TYPE_RETURN_B, 8'h7F);                  // quorum on 234: return
        send_response('1, '1, 8'hFE);                             // top set, all-ones key
        send_response('1, '0, FLAG_CLEARED);                      // quorum, plain forward
        // five keys into one set: the fifth finds it full
        for (int i = 1; i <= 5; i++)
            send_response({56'(i), 8'h05}, 16'(i), 8'(i + 1));
        send_response({56'd5, 8'h05}, '0, 8'h02);                 // still not stored
        send_response({56'd1, 8'h05}, TYPE_RETURN_A, 8'h40);      // quorum, return
        send_response({56'd1, 8'h05}, '0, 8'h20);                 // freed, way 0 opens
        send_response({56'd5, 8'h05}, '0, 8'h10);                 // takes the freed way
        send_response(64'h8000_0000_0000_0005, TYPE_RETURN_B, 8'h55); // full again
        send_response({56'd2, 8'h05}, 16'hAAAA, 8'hAA);           // quorum, forward

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                write_settings(PHASE_REPLICAS[p], PHASE_QUORUM[p]);
            end
            if (p == PHASES - 1)
                calm = 1'b1;

            // a fresh key pool over three random sets; low bits pick the set
            for (int s = 0; s < 3; s++)
                pool_sets[s] = $urandom_range(0, SETS - 1);
            for (int k = 0; k < POOL_KEYS; k++)
            begin
                key     = {$urandom, $urandom};
                pool[k] = (key / 64'(SETS)) * 64'(SETS) + 64'(pool_sets[k % 3]);
            end

            // with no freeing and quorum 15 one key runs into count saturation
            if (PHASE_REPLICAS[p] == 0 && PHASE_QUORUM[p] == 15)
            begin
                key = {$urandom, $urandom};
                repeat (17)
                    send_response(key, TYPE_RETURN_A, 8'h33);
            end

            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // mostly repeated keys from the pool, some fresh ones
                if ($urandom_range(0, 99) < 85)
                    key = pool[$urandom_range(0, POOL_KEYS - 1)];
                else
                    key = {$urandom, $urandom};
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    mtype = TYPE_RETURN_A;
                else if (pick < 50)
                    mtype = TYPE_RETURN_B;
                else if (pick < 55)
                    mtype = TYPE_RETURN_A + 1'b1;
                else
                    mtype = TYPE_W'($urandom_range(0, 65535));
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    flag = FLAG_RETURNED;
                else if (pick < 12)
                    flag = FLAG_RETURN_MARK;
                else if (pick < 16)
                    flag = FLAG_CLEARED;
                else
                    flag = FLAG_W'($urandom_range(0, 255));
                send_response(key, mtype, flag);
            end
        end

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("** quorum_duplicate_filter_top: PASSED **");
        else
            $display("** quorum_duplicate_filter_top: FAILED **");
        $finish;
    end

endmodule

[quorum_duplicate_filter_top.f]
rtl/qdf_pkg.sv
rtl/qdf_if.sv
rtl/qdf_ctrl.sv
rtl/qdf_dp.sv
rtl/quorum_duplicate_filter_top.sv
rtl/qdf_checker.sv
tb/quorum_verdict_checker.sv
tb/tb_quorum_duplicate_filter_top.sv
